[design/mtd_pkg.sv]
// ----------------------------------------------------------------------------
// mtd_pkg: shared types and constants
// Widths of the move-toward-destination datapath and the queue entry format.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mtd_pkg;

  localparam int unsigned CoordW   = 32;  // Q16.16 coordinates and speed
  localparam int unsigned DtW      = 31;  // frame time
  localparam int unsigned ThrW     = 31;  // arrival threshold
  localparam int unsigned DiffW    = 33;  // exact coordinate difference
  localparam int unsigned SqW      = 65;  // square of a difference magnitude
  localparam int unsigned RadW     = 66;  // sum of squares
  localparam int unsigned RootW    = 33;  // floor square root of the sum
  localparam int unsigned RemW     = 36;  // square root partial remainder
  localparam int unsigned StepW    = 46;  // speed * frame time, Q30.16
  localparam int unsigned NumW     = 64;  // magnitude * speed
  localparam int unsigned QuotW    = 31;  // velocity magnitude

  localparam int unsigned SqrtStages = RootW;
  localparam int unsigned DivStages  = QuotW;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = 2;
  localparam int unsigned FifoCntW  = 3;

  localparam int unsigned InTdataW  = 192;
  localparam int unsigned OutTdataW = 128;

  localparam logic [ThrW-1:0] ThrReset = 31'd655;

  // One classified item as it waits between the front and the back.
  typedef struct packed {
    logic              early;   // speed not positive
    logic [CoordW-1:0] pos_x;
    logic [CoordW-1:0] pos_y;
    logic [CoordW-1:0] dest_x;
    logic [CoordW-1:0] dest_y;
    logic              neg_x;
    logic              neg_y;
    logic [SqW-1:0]    sqx;
    logic [SqW-1:0]    sqy;
    logic [StepW-1:0]  step;
    logic [NumW-1:0]   numx;
    logic [NumW-1:0]   numy;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

[design/mtd_fifo.sv]
// ----------------------------------------------------------------------------
// mtd_fifo: classified item queue
// Short queue that decouples the front classifier from the back pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mtd_fifo (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire mtd_pkg::item_t  item_i,
  input  wire logic            pop_i,
  output mtd_pkg::item_t       item_o,
  output mtd_pkg::q_stat_t     stat_o
);
  import mtd_pkg::*;

  item_t               mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FifoCntW-1:0] count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= item_i;
  end

  assign item_o       = mem_q[rd_ptr_q];
  assign stat_o.full  = (count_q == FifoCntW'(FifoDepth));
  assign stat_o.empty = (count_q == '0);

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FifoCntW'(FifoDepth)) else $error("queue count over depth");
  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |=> count_q == $past(count_q) + 1'b1)
    else $error("queue count did not grow on push");
  a_count_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i && !push_i |=> count_q == $past(count_q) - 1'b1)
    else $error("queue count did not shrink on pop");

endmodule

`default_nettype wire

[design/mtd_front.sv]
// ----------------------------------------------------------------------------
// mtd_front: input classifier
// Takes input transfers, forms the exact differences and the products that
// the back pipeline needs, and pushes one classified item into the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mtd_front (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  wire logic [mtd_pkg::InTdataW-1:0] s_axis_tdata_i,
  input  wire mtd_pkg::q_stat_t            q_stat_i,
  output logic                             q_push_o,
  output mtd_pkg::item_t                   q_item_o
);
  import mtd_pkg::*;

  typedef struct packed {
    logic [CoordW-1:0] pos_x;
    logic [CoordW-1:0] pos_y;
    logic [CoordW-1:0] dest_x;
    logic [CoordW-1:0] dest_y;
    logic [CoordW-1:0] spd;
    logic [DtW-1:0]    dt;
    logic [DiffW-1:0]  ax;
    logic [DiffW-1:0]  ay;
    logic              neg_x;
    logic              neg_y;
  } s1_t;

  logic  v1_q, v2_q, en;
  s1_t   s1_d, s1_q;
  item_t s2_d, s2_q;
  logic [DiffW-1:0]  dx, dy;
  logic [RadW-1:0]   sqx_w, sqy_w;
  logic [2*DtW-1:0]  step_w;

  // The two stages move together; they hold only while the queue is full.
  assign en              = !(v2_q && q_stat_i.full);
  assign s_axis_tready_o = en;
  assign q_push_o        = v2_q && !q_stat_i.full;
  assign q_item_o        = s2_q;

  always_comb begin
    s1_d.pos_x  = s_axis_tdata_i[31:0];
    s1_d.pos_y  = s_axis_tdata_i[63:32];
    s1_d.dest_x = s_axis_tdata_i[95:64];
    s1_d.dest_y = s_axis_tdata_i[127:96];
    s1_d.spd    = s_axis_tdata_i[159:128];
    s1_d.dt     = s_axis_tdata_i[190:160];
    dx = {s1_d.dest_x[CoordW-1], s1_d.dest_x} - {s1_d.pos_x[CoordW-1], s1_d.pos_x};
    dy = {s1_d.dest_y[CoordW-1], s1_d.dest_y} - {s1_d.pos_y[CoordW-1], s1_d.pos_y};
    s1_d.neg_x = dx[DiffW-1];
    s1_d.neg_y = dy[DiffW-1];
    s1_d.ax    = dx[DiffW-1] ? -dx : dx;
    s1_d.ay    = dy[DiffW-1] ? -dy : dy;
  end

  always_comb begin
    sqx_w  = RadW'(s1_q.ax) * RadW'(s1_q.ax);
    sqy_w  = RadW'(s1_q.ay) * RadW'(s1_q.ay);
    step_w = (2*DtW)'(s1_q.spd[CoordW-2:0]) * (2*DtW)'(s1_q.dt);
    s2_d.early  = s1_q.spd[CoordW-1] || (s1_q.spd == '0);
    s2_d.pos_x  = s1_q.pos_x;
    s2_d.pos_y  = s1_q.pos_y;
    s2_d.dest_x = s1_q.dest_x;
    s2_d.dest_y = s1_q.dest_y;
    s2_d.neg_x  = s1_q.neg_x;
    s2_d.neg_y  = s1_q.neg_y;
    s2_d.sqx    = sqx_w[SqW-1:0];
    s2_d.sqy    = sqy_w[SqW-1:0];
    s2_d.step   = step_w[2*DtW-1:16];
    s2_d.numx   = NumW'(s1_q.ax) * NumW'(s1_q.spd[CoordW-2:0]);
    s2_d.numy   = NumW'(s1_q.ay) * NumW'(s1_q.spd[CoordW-2:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q <= s1_d;
      s2_q <= s2_d;
    end
  end

endmodule

`default_nettype wire

[design/mtd_back.sv]
// ----------------------------------------------------------------------------
// mtd_back: distance, arrival and velocity pipeline
// Pipelined square root, arrival decision and two pipelined dividers,
// ending in the output register of the result stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mtd_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_wr_en_i,
  input  wire logic [mtd_pkg::ThrW-1:0]      cfg_wr_data_i,
  input  wire mtd_pkg::item_t                q_item_i,
  input  wire mtd_pkg::q_stat_t              q_stat_i,
  output logic                               q_pop_o,
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  output logic [mtd_pkg::OutTdataW-1:0]      m_axis_tdata_o,
  output logic                               m_axis_tuser_o
);
  import mtd_pkg::*;

  typedef struct packed {
    logic              early;
    logic [CoordW-1:0] pos_x;
    logic [CoordW-1:0] pos_y;
    logic [CoordW-1:0] dest_x;
    logic [CoordW-1:0] dest_y;
    logic              neg_x;
    logic              neg_y;
    logic [StepW-1:0]  step;
    logic [NumW-1:0]   numx;
    logic [NumW-1:0]   numy;
    logic [RadW-1:0]   rad;
    logic [RemW-1:0]   rem;
    logic [RootW-1:0]  root;
  } sq_t;

  typedef struct packed {
    logic              arrived;
    logic [CoordW-1:0] out_x;
    logic [CoordW-1:0] out_y;
    logic              neg_x;
    logic              neg_y;
    logic [RootW-1:0]  divisor;
    logic [NumW-1:0]   remx;
    logic [NumW-1:0]   remy;
    logic [QuotW-1:0]  qx;
    logic [QuotW-1:0]  qy;
  } dv_t;

  // One bit pair of the restoring square root.
  function automatic sq_t sqrt_step(input sq_t s);
    sq_t              r;
    logic [RemW-1:0]  rem2;
    logic [RemW-1:0]  trial;
    r     = s;
    rem2  = {s.rem[RemW-3:0], s.rad[RadW-1 -: 2]};
    trial = RemW'({s.root, 2'b01});
    r.rad = {s.rad[RadW-3:0], 2'b00};
    if (rem2 >= trial) begin
      r.rem  = rem2 - trial;
      r.root = {s.root[RootW-2:0], 1'b1};
    end else begin
      r.rem  = rem2;
      r.root = {s.root[RootW-2:0], 1'b0};
    end
    return r;
  endfunction

  // One quotient bit of both restoring dividers.
  function automatic dv_t div_step(input dv_t d, input int unsigned bitpos);
    dv_t            r;
    logic [NumW-1:0] cand;
    r    = d;
    cand = NumW'(d.divisor) << bitpos;
    if (d.remx >= cand) begin
      r.remx         = d.remx - cand;
      r.qx[bitpos]   = 1'b1;
    end
    if (d.remy >= cand) begin
      r.remy         = d.remy - cand;
      r.qy[bitpos]   = 1'b1;
    end
    return r;
  endfunction

  logic [ThrW-1:0]       thr_q;
  logic                  en;
  logic [SqrtStages:0]   sv_q;
  sq_t                   sq_q [SqrtStages+1];
  sq_t                   sq_load;
  logic [DivStages:0]    dvv_q;
  dv_t                   dv_q [DivStages+1];
  dv_t                   dv_load;
  logic [RootW-1:0]      root_w;
  logic [CoordW-1:0]     vel_x, vel_y;
  logic                  out_valid_q;
  logic [OutTdataW-1:0]  tdata_q;
  logic                  tuser_q;

  // The whole pipeline holds only while a finished result waits.
  assign en      = !out_valid_q || m_axis_tready_i;
  assign q_pop_o = en && !q_stat_i.empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThrReset;
    end else if (cfg_wr_en_i) begin
      thr_q <= cfg_wr_data_i;
    end
  end

  always_comb begin
    sq_load.early  = q_item_i.early;
    sq_load.pos_x  = q_item_i.pos_x;
    sq_load.pos_y  = q_item_i.pos_y;
    sq_load.dest_x = q_item_i.dest_x;
    sq_load.dest_y = q_item_i.dest_y;
    sq_load.neg_x  = q_item_i.neg_x;
    sq_load.neg_y  = q_item_i.neg_y;
    sq_load.step   = q_item_i.step;
    sq_load.numx   = q_item_i.numx;
    sq_load.numy   = q_item_i.numy;
    sq_load.rad    = RadW'(q_item_i.sqx) + RadW'(q_item_i.sqy);
    sq_load.rem    = '0;
    sq_load.root   = '0;
  end

  always_comb begin
    root_w = sq_q[SqrtStages].root;
    dv_load.arrived = sq_q[SqrtStages].early
                   || (root_w <= RootW'(thr_q))
                   || (sq_q[SqrtStages].step >= StepW'(root_w));
    dv_load.out_x = dv_load.arrived ? sq_q[SqrtStages].dest_x : sq_q[SqrtStages].pos_x;
    dv_load.out_y = dv_load.arrived ? sq_q[SqrtStages].dest_y : sq_q[SqrtStages].pos_y;
    dv_load.neg_x   = sq_q[SqrtStages].neg_x;
    dv_load.neg_y   = sq_q[SqrtStages].neg_y;
    dv_load.divisor = root_w;
    dv_load.remx    = sq_q[SqrtStages].numx;
    dv_load.remy    = sq_q[SqrtStages].numy;
    dv_load.qx      = '0;
    dv_load.qy      = '0;
  end

  // The quotient never exceeds the speed, so it always fits in 31 bits.
  always_comb begin
    if (dv_q[DivStages].arrived) begin
      vel_x = '0;
      vel_y = '0;
    end else begin
      vel_x = dv_q[DivStages].neg_x ? -CoordW'(dv_q[DivStages].qx)
                                    : CoordW'(dv_q[DivStages].qx);
      vel_y = dv_q[DivStages].neg_y ? -CoordW'(dv_q[DivStages].qy)
                                    : CoordW'(dv_q[DivStages].qy);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q        <= '0;
      dvv_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      sv_q        <= {sv_q[SqrtStages-1:0], q_pop_o};
      dvv_q       <= {dvv_q[DivStages-1:0], sv_q[SqrtStages]};
      out_valid_q <= dvv_q[DivStages];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_q[0] <= sq_load;
      for (int unsigned k = 1; k <= SqrtStages; k++) begin
        sq_q[k] <= sqrt_step(sq_q[k-1]);
      end
      dv_q[0] <= dv_load;
      for (int unsigned k = 1; k <= DivStages; k++) begin
        dv_q[k] <= div_step(dv_q[k-1], QuotW - k);
      end
      tdata_q <= {vel_y, vel_x, dv_q[DivStages].out_y, dv_q[DivStages].out_x};
      tuser_q <= dv_q[DivStages].arrived;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = tdata_q;
  assign m_axis_tuser_o  = tuser_q;

  a_arrived_still: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && tuser_q |-> tdata_q[OutTdataW-1:64] == '0)
    else $error("arrived result carries a velocity");
  a_moving_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dvv_q[0] && !dv_q[0].arrived |-> dv_q[0].divisor != '0)
    else $error("moving item divides by zero distance");
  a_vel_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !tuser_q |-> tdata_q[95:64] != 32'h8000_0000
                             && tdata_q[127:96] != 32'h8000_0000)
    else $error("velocity exceeds speed range");

endmodule

`default_nettype wire

[design/move_toward_destination_step_top.sv]
// ----------------------------------------------------------------------------
// move_toward_destination_step_top: move-toward-destination step
// Decides per entity whether it reaches its destination this frame and
// gives the new position and velocity.
// ----------------------------------------------------------------------------
// Stages from an input transfer to its result: two front stages, one queue
//   slot, one sum stage, 33 square root stages, one compare stage, 31
//   divider stages and the output register.
// Throughput: one item per cycle while the output is not stalled; the square
//   root and dividers are fully pipelined, one bit per stage.
// Reset clears all valid bits and sets the threshold to 655; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module move_toward_destination_step_top (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_wr_en_i,
  input  wire logic [mtd_pkg::ThrW-1:0]       cfg_wr_data_i,   // arrive_threshold
  input  wire logic                           s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // pos_x, pos_y, dest_x, dest_y, speed, frame time, one zero pad bit
  input  wire logic [mtd_pkg::InTdataW-1:0]   s_axis_tdata_i,
  output logic                                m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  // out_pos_x, out_pos_y, vel_x, vel_y
  output logic [mtd_pkg::OutTdataW-1:0]       m_axis_tdata_o,
  // arrived
  output logic                                m_axis_tuser_o
);
  import mtd_pkg::*;

  logic    push, pop;
  item_t   push_item, pop_item;
  q_stat_t q_stat;

  mtd_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .q_stat_i        (q_stat),
    .q_push_o        (push),
    .q_item_o        (push_item)
  );

  mtd_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (push_item),
    .pop_i  (pop),
    .item_o (pop_item),
    .stat_o (q_stat)
  );

  mtd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_wr_en_i     (cfg_wr_en_i),
    .cfg_wr_data_i   (cfg_wr_data_i),
    .q_item_i        (pop_item),
    .q_stat_i        (q_stat),
    .q_pop_o         (pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

endmodule

`default_nettype wire

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: move-toward-destination step testbench
// Drives entity items into the step block, predicts arrival, position and
// velocity for each one in exact integer arithmetic and compares every
// result transfer in order, under random idling and long output stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import mtd_pkg::*;

  localparam int unsigned Latency = 70;

  typedef struct packed {
    logic              arrived;
    logic [CoordW-1:0] pos_x;
    logic [CoordW-1:0] pos_y;
    logic [CoordW-1:0] vel_x;
    logic [CoordW-1:0] vel_y;
  } motion_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_wr_en_i = 1'b0;
  logic [ThrW-1:0]      cfg_wr_data_i = '0;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  logic [InTdataW-1:0]  s_axis_tdata_i = '0;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata_o;
  logic                 m_axis_tuser_o;

  logic [ThrW-1:0] threshold = ThrReset;
  motion_t         expected_motion[$];
  int              send_idle_pct = 0;
  int              recv_idle_pct = 0;
  int              hold_off = 0;
  int              n_errors = 0;

  move_toward_destination_step_top uut (.*);

  always #1 clk_i = ~clk_i;

  function automatic logic [RootW-1:0] floor_root(logic [RadW-1:0] v);
    logic [RootW-1:0] r;
    logic [RootW-1:0] c;
    r = '0;
    for (int b = RootW - 1; b >= 0; b--) begin
      c = r | (33'd1 << b);
      if ({66'd0, c} * {66'd0, c} <= {66'd0, v}) r = c;
    end
    return r;
  endfunction

  function automatic motion_t predict_motion(logic [InTdataW-1:0] d);
    logic signed [CoordW-1:0] px, py, qx, qy, spd;
    logic [DtW-1:0]           dt;
    logic signed [DiffW:0]    dx, dy;
    logic [DiffW-1:0]         ax, ay;
    logic [RadW-1:0]          sum;
    logic [RootW-1:0]         root_v;
    logic [StepW+16:0]        step;
    logic [96:0]              mx, my;
    motion_t                  m;
    {dt, spd, qy, qx, py, px} = d[190:0];
    m = '0;
    m.arrived = 1'b1;
    if (spd > 0) begin
      dx = $signed({qx[31], qx}) - $signed({py[31], py}) * 0 - $signed({px[31], px});
      dy = $signed({qy[31], qy}) - $signed({py[31], py});
      ax = DiffW'(dx < 0 ? -dx : dx);
      ay = DiffW'(dy < 0 ? -dy : dy);
      sum = {33'd0, ax} * {33'd0, ax} + {33'd0, ay} * {33'd0, ay};
      root_v = floor_root(sum);
      step = ({31'd0, spd} * {32'd0, dt}) >> 16;
      if (!(root_v <= {2'd0, threshold} || step >= root_v)) begin
        m.arrived = 1'b0;
        mx = ({64'd0, ax} * {65'd0, spd}) / root_v;
        my = ({64'd0, ay} * {65'd0, spd}) / root_v;
        if (mx > 97'h7FFFFFFF) mx = 97'h7FFFFFFF;
        if (my > 97'h7FFFFFFF) my = 97'h7FFFFFFF;
        m.vel_x = dx < 0 ? -mx[31:0] : mx[31:0];
        m.vel_y = dy < 0 ? -my[31:0] : my[31:0];
      end
    end
    m.pos_x = m.arrived ? qx : px;
    m.pos_y = m.arrived ? qy : py;
    return m;
  endfunction

  // Valid stays high after a transfer so that items can follow back to back;
  // it drops while the sender idles and before the sender waits for results.
  task automatic send_entity(logic [31:0] px, py, qx, qy, spd, logic [DtW-1:0] dt);
    logic [InTdataW-1:0] d;
    d = {1'b0, dt, spd, qy, qx, py, px};
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tdata_i  <= d;
    s_axis_tvalid_i <= 1'b1;
    expected_motion.push_back(predict_motion(d));
    do @(posedge clk_i); while (!s_axis_tready_o);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    while (expected_motion.size() != 0) @(negedge clk_i);
    repeat (Latency + 4) @(negedge clk_i);
  endtask

  task automatic write_threshold(logic [ThrW-1:0] v);
    wait_drained();
    cfg_wr_data_i <= v;
    cfg_wr_en_i   <= 1'b1;
    @(negedge clk_i);
    cfg_wr_en_i <= 1'b0;
    threshold = v;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(2000) - 1000;
      2: return {{8{1'($urandom_range(1))}}, 24'($urandom)};
      default: return {16'($urandom_range(400) - 200), 16'($urandom)};
    endcase
  endfunction

  task automatic test_directed();
    send_entity(0, 0, 100 << 16, 0, 32'h8000_0000, 31'h7FFF_FFFF);  // negative speed
    send_entity(5, 5, 1 << 16, 0, 0, 31'd65536);                      // zero speed
    send_entity(7, 7, 7, 7, 1 << 16, 31'd0);                          // coincident
    send_entity(0, 0, 600, 0, 1 << 16, 31'd0);                        // within threshold
    send_entity(0, 0, 10 << 16, 0, 1 << 16, 31'd0);                   // zero frame time
    send_entity(0, 0, 10 << 16, 0, 10 << 16, 31'd65536);              // step reaches
    send_entity(0, 0, 10 << 16, 3 << 16, 1 << 16, 31'd65536);
    send_entity(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h7FFF_FFFF, 31'd0);                                // widest span
    send_entity(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                32'h7FFF_FFFF, 31'd1);
    send_entity(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 0, 1, 31'h7FFF_FFFF);
    send_entity(0, 0, -(3 << 16), -(4 << 16), 2 << 16, 31'd32768);
    send_entity(0, 0, 656, 0, 1, 31'd0);
    write_threshold('0);
    send_entity(3, 3, 3, 3, 1 << 16, 31'd0);                          // zero threshold
    send_entity(0, 0, 1, 0, 1 << 16, 31'd0);
    write_threshold(31'h7FFF_FFFF);
    send_entity(32'h8000_0000, 0, 32'h7FFF_FFFF, 0, 1, 31'd0);
    send_entity(0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 31'd0);
  endtask

  task automatic test_random(int n, int s_pct, int r_pct);
    logic [31:0] px, py;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int i = 0; i < n; i++) begin
      px = rand_coord();
      py = rand_coord();
      send_entity(px, py,
                  $urandom_range(1) ? rand_coord() : px + $urandom_range(1400) - 700,
                  $urandom_range(1) ? rand_coord() : py + $urandom_range(1400) - 700,
                  $urandom_range(9) == 0 ? $urandom : $urandom_range(32'h7F_FFFF),
                  $urandom_range(3) == 0 ? 31'($urandom)
                                         : 31'($urandom_range(1 << 17)));
    end
  endtask

  // Enough items to fill every pipeline stage and the queue while the
  // receiver holds off, so the input stalls.
  task automatic test_backpressure();
    hold_off = 300;
    send_idle_pct = 0;
    test_random(120, 0, 0);
    wait_drained();
  endtask

  // Receiver: random idling plus the long hold-off, counted in cycles.
  always @(negedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= $urandom_range(99) >= recv_idle_pct;
    end
  end

  always @(posedge clk_i) begin
    motion_t got, exp_m;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.arrived = m_axis_tuser_o;
      got.pos_x   = m_axis_tdata_o[31:0];
      got.pos_y   = m_axis_tdata_o[63:32];
      got.vel_x   = m_axis_tdata_o[95:64];
      got.vel_y   = m_axis_tdata_o[127:96];
      if (expected_motion.size() == 0) begin
        $error("unexpected result transfer");
        n_errors++;
      end else begin
        exp_m = expected_motion.pop_front();
        if (got.arrived !== exp_m.arrived) begin
          $error("arrived: expected %0d, got %0d", exp_m.arrived, got.arrived);
          n_errors++;
        end
        if (got.pos_x !== exp_m.pos_x) begin
          $error("out_pos_x: expected %h, got %h", exp_m.pos_x, got.pos_x);
          n_errors++;
        end
        if (got.pos_y !== exp_m.pos_y) begin
          $error("out_pos_y: expected %h, got %h", exp_m.pos_y, got.pos_y);
          n_errors++;
        end
        if (got.vel_x !== exp_m.vel_x) begin
          $error("vel_x: expected %h, got %h", exp_m.vel_x, got.vel_x);
          n_errors++;
        end
        if (got.vel_y !== exp_m.vel_y) begin
          $error("vel_y: expected %h, got %h", exp_m.vel_y, got.vel_y);
          n_errors++;
        end
      end
    end
  end

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    recv_idle_pct = 20;
    test_directed();
    write_threshold(ThrReset);
    test_random(300, 16, 85);
    test_backpressure();
    write_threshold(31'd40000);
    test_random(300, 85, 16);
    write_threshold(31'd1);
    test_random(300, 0, 0);
    wait_drained();
    if (n_errors == 0 && expected_motion.size() == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule

[filelist.f]
design/mtd_pkg.sv
design/mtd_fifo.sv
design/mtd_front.sv
design/mtd_back.sv
design/move_toward_destination_step_top.sv
tb/tb_top.sv
